[hw/rtl/fvn_pkg.sv]
package fvn_pkg;

  // Field and register widths.
  parameter int COORD_W    = 32;
  parameter int ABS_W      = 31;
  parameter int VAL_W      = 16;
  parameter int IDX_W      = 6;
  parameter int OCTCFG_W   = 4;
  parameter int DECAY_W    = 16;
  parameter int GROWTH_W   = 11;
  parameter int CFG_IDX_W  = 2;
  parameter int CFG_DATA_W = 16;

  // Shared multiplier: 32 by 32 bits, registered 64-bit product.
  parameter int MUL_W  = 32;
  parameter int PROD_W = 64;

  // Running frequency (Q.8) and running amplitude (Q1.16).
  parameter int FREQ_W = 32;
  parameter int AMP_W  = 17;
  parameter logic [FREQ_W-1:0] FREQ_ONE = 32'd256;
  parameter logic [AMP_W-1:0]  AMP_ONE  = 17'h10000;

  // Interpolation weights are 1.0 minus the Q0.16 fraction.
  parameter int WGT_W  = 17;
  parameter int LERP_W = 32;
  parameter int VACC_W = 48;

  // Integer part of the scaled point, reduced 8 bits per cycle.
  parameter int IP_W      = 39;
  parameter int CH_W      = 8;
  parameter int NCH       = 5;
  parameter int IPAD_W    = NCH * CH_W;
  parameter int MOD_CNT_W = $clog2(NCH);

  // Normalizing divider, one quotient bit per cycle.
  parameter int DIV_STEPS = 16;
  parameter int DIV_CNT_W = $clog2(DIV_STEPS);

  // Reset values of the configuration registers.
  parameter logic [OCTCFG_W-1:0] OCT_RESET    = 4'd4;
  parameter logic [DECAY_W-1:0]  DECAY_RESET  = 16'd32768;
  parameter logic [GROWTH_W-1:0] GROWTH_RESET = 11'd512;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OCTAVE_COUNT     = 2'd0,
    CFG_AMPLITUDE_DECAY  = 2'd1,
    CFG_FREQUENCY_GROWTH = 2'd2
  } cfg_idx_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_MUL_PX,
    S_MUL_PY,
    S_CAP_Y,
    S_MOD,
    S_RD0,
    S_RD1,
    S_RD2,
    S_RD3,
    S_IP0,
    S_IP1,
    S_IP2,
    S_IP3,
    S_TERM,
    S_ACC,
    S_DIV_INIT,
    S_DIV
  } state_e;

  // Absolute value of a Q16.16 coordinate; the most negative value saturates.
  function automatic logic [ABS_W-1:0] abs_sat(input logic [COORD_W-1:0] c);
    logic [COORD_W-1:0] neg;
    neg = -c;
    if (!c[COORD_W-1]) begin
      return c[ABS_W-1:0];
    end else if (neg[COORD_W-1]) begin
      return '1;
    end else begin
      return neg[ABS_W-1:0];
    end
  endfunction

endpackage

[hw/rtl/fvn_ram.sv]
module fvn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // One write port and one read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

[hw/rtl/fractal_value_noise_2d_top.sv]
// Channel  | Direction | Signals                                        | Handshake
// ---------+-----------+------------------------------------------------+------------------------
// request  | in        | operation_i, x/y_coord_i, entry_col/row/value_i | start & !busy
// result   | out       | noise_value_o                                  | noise_valid_o, 1 cycle
// config   | in        | cfg_index_i, cfg_data_i                        | cfg_valid_i & cfg_ready_o
//
// A lattice write takes effect at its accept edge and leaves the block idle.
// A sample keeps busy high through each octave (one shared 32x32 multiplier,
// a chunked modulo reduction and four reads of the single-port lattice read side)
// and then through the bit-serial normalizing divider, which a saturating sum skips;
// the strobe comes in the first idle cycle after that.
// Reset clears the state machine and loads the register defaults; the lattice
// holds no reset value. The receiver cannot stall, so results are never held.
module fractal_value_noise_2d_top
  import fvn_pkg::*;
#(
  parameter int RES          = 64,
  parameter int MAX_OCTAVES  = 8,
  parameter int LATTICE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic                  operation_i,
  input  logic [COORD_W-1:0]    x_coord_i,
  input  logic [COORD_W-1:0]    y_coord_i,
  input  logic [IDX_W-1:0]      entry_col_i,
  input  logic [IDX_W-1:0]      entry_row_i,
  input  logic [VAL_W-1:0]      entry_value_i,
  output logic                  noise_valid_o,
  output logic [VAL_W-1:0]      noise_value_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int RES_W      = (RES > 1) ? $clog2(RES) : 1;
  localparam int ADDR_W     = $clog2(RES * RES);
  localparam int OCT_W      = $clog2(MAX_OCTAVES + 1);
  localparam int NRM_W      = $clog2(MAX_OCTAVES * 65536 + 1);
  localparam int ACC_W      = $clog2(MAX_OCTAVES * 65535 + 1);
  localparam int UP_SHIFT   = (LATTICE_BITS >= 16) ? (LATTICE_BITS - 16) : 0;
  localparam int DOWN_SHIFT = (LATTICE_BITS < 16) ? (16 - LATTICE_BITS) : 0;

  // Configuration registers.
  logic [OCTCFG_W-1:0] octave_count_q;
  logic [DECAY_W-1:0]  amplitude_decay_q;
  logic [GROWTH_W-1:0] frequency_growth_q;

  // Sequencer state.
  state_e                 state_q, state_d;
  logic [OCT_W-1:0]       oct_q, oct_d;
  logic [OCT_W-1:0]       n_q, n_d;
  logic [MOD_CNT_W-1:0]   mod_cnt_q, mod_cnt_d;
  logic [DIV_CNT_W-1:0]   div_cnt_q, div_cnt_d;
  logic                   noise_valid_q, noise_valid_d;

  // Datapath registers.
  logic [ABS_W-1:0]  ax_q, ax_d, ay_q, ay_d;
  logic [FREQ_W-1:0] freq_q, freq_d;
  logic [AMP_W-1:0]  amp_q, amp_d, amp_nxt_q, amp_nxt_d;
  logic [NRM_W-1:0]  norm_q, norm_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [VAL_W-1:0]  tx_q, tx_d, ty_q, ty_d;
  logic [IPAD_W-1:0] ix_q, ix_d, iy_q, iy_d;
  logic [RES_W-1:0]  rx_q, rx_d, ry_q, ry_d;
  logic [LERP_W-1:0] lerp_a_q, lerp_a_d, lerp_b_q, lerp_b_d;
  logic [VACC_W-1:0] vacc_q, vacc_d;
  logic [VAL_W-1:0]  v_q, v_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [NRM_W-1:0]  rem_q, rem_d;
  logic [VAL_W-1:0]  quot_q, quot_d;
  logic [VAL_W-1:0]  noise_value_q, noise_value_d;

  // Combinational helpers.
  logic                    accept;
  logic [OCT_W-1:0]        eff_oct;
  logic [RES_W-1:0]        rx1, ry1;
  logic [WGT_W-1:0]        wx0, wy0;
  logic [MUL_W-1:0]        mul_a, mul_b;
  logic [RES_W-1:0]        rd_col, rd_row;
  logic [ADDR_W-1:0]       rd_addr, wr_addr;
  logic                    wr_en;
  logic [LATTICE_BITS-1:0] wr_data, rd_data;
  logic [VAL_W-1:0]        rd_val;
  logic [VACC_W-1:0]       vsum;
  logic [34:0]             fsh;
  logic [NRM_W:0]          rem2;
  logic                    qbit;

  // Remainder of (rem * 2^CH_W + chunk) modulo RES, one bit per step.
  function automatic logic [RES_W-1:0] mod_chunk(input logic [RES_W-1:0] rem,
                                                 input logic [CH_W-1:0] chunk);
    logic [RES_W:0] r;
    r = {1'b0, rem};
    for (int k = CH_W - 1; k >= 0; k--) begin
      r = {r[RES_W-1:0], chunk[k]};
      if (r >= (RES_W + 1)'(RES)) begin
        r = r - (RES_W + 1)'(RES);
      end
    end
    return r[RES_W-1:0];
  endfunction

  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = !busy;

  assign noise_valid_o = noise_valid_q;
  assign noise_value_o = noise_value_q;

  // Octave count clamped to 1..MAX_OCTAVES.
  always_comb begin
    if (octave_count_q == '0) begin
      eff_oct = OCT_W'(1);
    end else if (int'(octave_count_q) > MAX_OCTAVES) begin
      eff_oct = OCT_W'(MAX_OCTAVES);
    end else begin
      eff_oct = OCT_W'(octave_count_q);
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      octave_count_q     <= OCT_RESET;
      amplitude_decay_q  <= DECAY_RESET;
      frequency_growth_q <= GROWTH_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_OCTAVE_COUNT:     octave_count_q     <= cfg_data_i[OCTCFG_W-1:0];
        CFG_AMPLITUDE_DECAY:  amplitude_decay_q  <= cfg_data_i[DECAY_W-1:0];
        CFG_FREQUENCY_GROWTH: frequency_growth_q <= cfg_data_i[GROWTH_W-1:0];
        default: ;
      endcase
    end
  end

  // Neighbor cells wrap around the lattice edge.
  assign rx1 = (rx_q == RES_W'(RES - 1)) ? '0 : RES_W'(rx_q + 1'b1);
  assign ry1 = (ry_q == RES_W'(RES - 1)) ? '0 : RES_W'(ry_q + 1'b1);
  assign wx0 = AMP_ONE - {1'b0, tx_q};
  assign wy0 = AMP_ONE - {1'b0, ty_q};

  // Lattice storage: write requests land directly, samples read four corners.
  assign wr_en   = accept && (operation_i == OP_WRITE) &&
                   (int'(entry_col_i) < RES) && (int'(entry_row_i) < RES);
  assign wr_addr = ADDR_W'(ADDR_W'(entry_col_i) * ADDR_W'(RES) + ADDR_W'(entry_row_i));
  assign wr_data = LATTICE_BITS'((32'(entry_value_i) << UP_SHIFT) >> DOWN_SHIFT);
  assign rd_addr = ADDR_W'(ADDR_W'(rd_col) * ADDR_W'(RES) + ADDR_W'(rd_row));
  assign rd_val  = VAL_W'((32'(rd_data) >> UP_SHIFT) << DOWN_SHIFT);

  always_comb begin
    unique case (state_q)
      S_RD1:   begin rd_col = rx1;  rd_row = ry_q; end
      S_RD2:   begin rd_col = rx_q; rd_row = ry1;  end
      S_RD3:   begin rd_col = rx1;  rd_row = ry1;  end
      default: begin rd_col = rx_q; rd_row = ry_q; end
    endcase
  end

  fvn_ram #(
    .WIDTH (LATTICE_BITS),
    .DEPTH (RES * RES)
  ) u_lattice (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (state_q)
      S_MUL_PX:     begin mul_a = MUL_W'(ax_q);     mul_b = freq_q;                       end
      S_MUL_PY:     begin mul_a = MUL_W'(ay_q);     mul_b = freq_q;                       end
      S_CAP_Y:      begin mul_a = freq_q;           mul_b = MUL_W'(frequency_growth_q);   end
      S_RD1, S_RD3: begin mul_a = MUL_W'(rd_val);   mul_b = MUL_W'(wx0);                  end
      S_RD2, S_IP0: begin mul_a = MUL_W'(rd_val);   mul_b = MUL_W'(tx_q);                 end
      S_IP1:        begin mul_a = lerp_a_q;         mul_b = MUL_W'(wy0);                  end
      S_IP2:        begin mul_a = lerp_b_q;         mul_b = MUL_W'(ty_q);                 end
      S_IP3:        begin mul_a = MUL_W'(amp_q);    mul_b = MUL_W'(amplitude_decay_q);    end
      S_TERM:       begin mul_a = MUL_W'(v_q);      mul_b = MUL_W'(amp_q);                end
      default:      begin mul_a = '0;               mul_b = '0;                           end
    endcase
  end

  assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign vsum = vacc_q + prod_q[VACC_W-1:0];
  assign fsh  = prod_q[42:8];
  assign rem2 = {rem_q, 1'b0};
  assign qbit = (rem2 >= {1'b0, norm_q});

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_d       = state_q;
    oct_d         = oct_q;
    n_d           = n_q;
    mod_cnt_d     = mod_cnt_q;
    div_cnt_d     = div_cnt_q;
    noise_valid_d = 1'b0;
    ax_d          = ax_q;
    ay_d          = ay_q;
    freq_d        = freq_q;
    amp_d         = amp_q;
    amp_nxt_d     = amp_nxt_q;
    norm_d        = norm_q;
    acc_d         = acc_q;
    tx_d          = tx_q;
    ty_d          = ty_q;
    ix_d          = ix_q;
    iy_d          = iy_q;
    rx_d          = rx_q;
    ry_d          = ry_q;
    lerp_a_d      = lerp_a_q;
    lerp_b_d      = lerp_b_q;
    vacc_d        = vacc_q;
    v_d           = v_q;
    rem_d         = rem_q;
    quot_d        = quot_q;
    noise_value_d = noise_value_q;

    unique case (state_q)
      // Take a sample request; write requests finish in the accept cycle.
      S_IDLE: begin
        if (accept && (operation_i == OP_SAMPLE)) begin
          ax_d    = abs_sat(x_coord_i);
          ay_d    = abs_sat(y_coord_i);
          freq_d  = FREQ_ONE;
          amp_d   = AMP_ONE;
          norm_d  = '0;
          acc_d   = '0;
          oct_d   = '0;
          n_d     = eff_oct;
          state_d = S_MUL_PX;
        end
      end
      // Scale x; the normalizer collects the same amplitudes as the sum.
      S_MUL_PX: begin
        norm_d  = norm_q + NRM_W'(amp_q);
        state_d = S_MUL_PY;
      end
      S_MUL_PY: begin
        tx_d    = prod_q[23:8];
        ix_d    = IPAD_W'(prod_q[IP_W+23:24]);
        state_d = S_CAP_Y;
      end
      S_CAP_Y: begin
        ty_d      = prod_q[23:8];
        iy_d      = IPAD_W'(prod_q[IP_W+23:24]);
        rx_d      = '0;
        ry_d      = '0;
        mod_cnt_d = '0;
        state_d   = S_MOD;
      end
      // Reduce both integer parts modulo RES; pick up the next frequency.
      S_MOD: begin
        if (mod_cnt_q == '0) begin
          freq_d = (|fsh[34:32]) ? '1 : fsh[31:0];
        end
        rx_d = mod_chunk(rx_q, ix_q[IPAD_W-1 -: CH_W]);
        ry_d = mod_chunk(ry_q, iy_q[IPAD_W-1 -: CH_W]);
        ix_d = {ix_q[IPAD_W-CH_W-1:0], CH_W'(0)};
        iy_d = {iy_q[IPAD_W-CH_W-1:0], CH_W'(0)};
        if (mod_cnt_q == MOD_CNT_W'(NCH - 1)) begin
          state_d = S_RD0;
        end else begin
          mod_cnt_d = mod_cnt_q + 1'b1;
        end
      end
      S_RD0: state_d = S_RD1;
      S_RD1: state_d = S_RD2;
      // Blend along x for the lower and the upper row.
      S_RD2: begin
        lerp_a_d = prod_q[LERP_W-1:0];
        state_d  = S_RD3;
      end
      S_RD3: begin
        lerp_a_d = lerp_a_q + prod_q[LERP_W-1:0];
        state_d  = S_IP0;
      end
      S_IP0: begin
        lerp_b_d = prod_q[LERP_W-1:0];
        state_d  = S_IP1;
      end
      S_IP1: begin
        lerp_b_d = lerp_b_q + prod_q[LERP_W-1:0];
        state_d  = S_IP2;
      end
      // Blend along y and truncate to Q0.16.
      S_IP2: begin
        vacc_d  = prod_q[VACC_W-1:0];
        state_d = S_IP3;
      end
      S_IP3: begin
        v_d     = vsum[VACC_W-1:32];
        state_d = S_TERM;
      end
      S_TERM: begin
        amp_nxt_d = prod_q[32:16];
        state_d   = S_ACC;
      end
      // Add the weighted octave and move on to the next octave or the divide.
      S_ACC: begin
        acc_d = acc_q + ACC_W'(prod_q[31:16]);
        amp_d = amp_nxt_q;
        if (OCT_W'(oct_q + 1'b1) == n_q) begin
          state_d = S_DIV_INIT;
        end else begin
          oct_d   = oct_q + 1'b1;
          state_d = S_MUL_PX;
        end
      end
      S_DIV_INIT: begin
        if (NRM_W'(acc_q) >= norm_q) begin
          noise_value_d = '1;
          noise_valid_d = 1'b1;
          state_d       = S_IDLE;
        end else begin
          rem_d     = NRM_W'(acc_q);
          quot_d    = '0;
          div_cnt_d = '0;
          state_d   = S_DIV;
        end
      end
      // Restoring division, one quotient bit per cycle.
      S_DIV: begin
        rem_d  = qbit ? NRM_W'(rem2 - {1'b0, norm_q}) : rem2[NRM_W-1:0];
        quot_d = {quot_q[VAL_W-2:0], qbit};
        if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          noise_value_d = {quot_q[VAL_W-2:0], qbit};
          noise_valid_d = 1'b1;
          state_d       = S_IDLE;
        end else begin
          div_cnt_d = div_cnt_q + 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      oct_q         <= '0;
      n_q           <= OCT_W'(1);
      mod_cnt_q     <= '0;
      div_cnt_q     <= '0;
      noise_valid_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      oct_q         <= oct_d;
      n_q           <= n_d;
      mod_cnt_q     <= mod_cnt_d;
      div_cnt_q     <= div_cnt_d;
      noise_valid_q <= noise_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    ax_q          <= ax_d;
    ay_q          <= ay_d;
    freq_q        <= freq_d;
    amp_q         <= amp_d;
    amp_nxt_q     <= amp_nxt_d;
    norm_q        <= norm_d;
    acc_q         <= acc_d;
    tx_q          <= tx_d;
    ty_q          <= ty_d;
    ix_q          <= ix_d;
    iy_q          <= iy_d;
    rx_q          <= rx_d;
    ry_q          <= ry_d;
    lerp_a_q      <= lerp_a_d;
    lerp_b_q      <= lerp_b_d;
    vacc_q        <= vacc_d;
    v_q           <= v_d;
    prod_q        <= prod_d;
    rem_q         <= rem_d;
    quot_q        <= quot_d;
    noise_value_q <= noise_value_d;
  end

  // A sample request starts the sequencer, so the block is busy once it is accepted.
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (operation_i == OP_SAMPLE)) |=> busy)
    else $error("sample request did not start the sequencer");

  // A lattice write request completes in its accept cycle.
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (operation_i == OP_WRITE)) |=> !busy)
    else $error("lattice write left the block busy");

  // A result only leaves the divider stage.
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    noise_valid_o |-> ($past(state_q == S_DIV) || $past(state_q == S_DIV_INIT)))
    else $error("result strobe without a finished division");

  // The octave counter stays within the clamped count.
  a_oct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (oct_q < n_q))
    else $error("octave counter ran past the octave count");

endmodule
